// ===== rtl/scst_pkg.sv =====
package scst_pkg;

    // One beat as it travels through the queue between front and back.
    typedef struct packed {
        logic [3:0] key;
        logic [7:0] tag;
        logic       last;
        logic       bad;
    } scst_entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREFIX,
        ST_SCATTER,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_EMPTY,
        ST_CLEAR
    } scst_state_t;

    localparam int unsigned QUEUE_DEPTH = 4;

endpackage

// ===== rtl/scst_front.sv =====
module scst_front #(
    parameter int unsigned NUM_KEYS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [3:0]           cfg_wr_data,
    input  logic [3:0]           key,
    input  logic [7:0]           tag,
    input  logic                 batch_end,
    output scst_pkg::scst_entry_t entry
);
    import scst_pkg::*;

    logic [3:0] max_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_key_reg <= 4'hF;
        end
        else if (cfg_wr_en)
        begin
            max_key_reg <= cfg_wr_data;
        end
    end

    // A key is refused when it lies above the programmed limit or outside the table.
    always_comb
    begin
        entry.key  = key;
        entry.tag  = tag;
        entry.last = batch_end;
        entry.bad  = (key > max_key_reg) || (32'(key) >= NUM_KEYS);
    end

endmodule

// ===== rtl/scst_queue.sv =====
module scst_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  scst_pkg::scst_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output scst_pkg::scst_entry_t head_data
);
    import scst_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    scst_entry_t        slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW:0]        fill_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (fill_reg == (PW+1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/scst_back.sv =====
module scst_back #(
    parameter int unsigned MAX_ITEMS = 64,
    parameter int unsigned NUM_KEYS  = 16,
    parameter int unsigned TAG_BITS  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  scst_pkg::scst_entry_t head_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            sorted_key,
    output logic [7:0]            sorted_tag,
    output logic                  final_res,
    output logic                  dropped,
    output logic                  empty_res
);
    import scst_pkg::*;

    localparam int unsigned IW  = $clog2(MAX_ITEMS);
    localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned KW  = $clog2(NUM_KEYS);
    localparam int unsigned TSW = (TAG_BITS < 8) ? TAG_BITS : 8;

    // Item stores in arrival order and in sorted order.
    logic [3:0]     key_mem [MAX_ITEMS];
    logic [TSW-1:0] tag_mem [MAX_ITEMS];
    logic [3:0]     skey_mem [MAX_ITEMS];
    logic [TSW-1:0] stag_mem [MAX_ITEMS];

    logic [CW-1:0]  cnt_reg [NUM_KEYS];
    logic [CW-1:0]  held_reg;
    logic           drop_reg;
    logic [KW-1:0]  pf_idx_reg;
    logic [CW-1:0]  acc_reg;
    logic [CW-1:0]  sc_idx_reg;
    logic           sc_pend_reg;
    logic [3:0]     rk_reg;
    logic [TSW-1:0] rt_reg;
    logic [CW-1:0]  em_idx_reg;
    logic [3:0]     ek_reg;
    logic [TSW-1:0] et_reg;

    logic           ov_reg;
    logic [3:0]     ok_reg;
    logic [7:0]     ot_reg;
    logic           ofin_reg;
    logic           odrop_reg;
    logic           oemp_reg;

    scst_state_t    state_reg;
    scst_state_t    state_next;

    logic           keep;
    logic           out_free;
    logic           ov_load;
    logic           sc_issue;
    logic           em_last;
    logic [KW-1:0]  rk_idx;
    logic [CW-1:0]  pos;

    assign keep     = !head_data.bad && (held_reg != CW'(MAX_ITEMS));
    assign out_free = !ov_reg || !out_stall;
    assign ov_load  = (state_reg == ST_EMIT_WR) || (state_reg == ST_EMPTY && out_free);
    assign sc_issue = (state_reg == ST_SCATTER) && (sc_idx_reg != held_reg);
    assign em_last  = (em_idx_reg == CW'(held_reg - 1'b1));
    assign rk_idx   = KW'(rk_reg);
    assign pos      = cnt_reg[rk_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                pop = head_valid;
                if (head_valid && head_data.last)
                begin
                    if (held_reg == '0 && !keep)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_PREFIX;
                    end
                end
            end
            ST_PREFIX:
            begin
                if (pf_idx_reg == KW'(NUM_KEYS - 1))
                begin
                    state_next = ST_SCATTER;
                end
            end
            ST_SCATTER:
            begin
                if (!sc_issue && !sc_pend_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT_WR;
                end
            end
            ST_EMIT_WR:
            begin
                state_next = em_last ? ST_CLEAR : ST_EMIT_RD;
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Arrival-order stores: written while loading, read during the scatter pass.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && head_valid && keep)
        begin
            key_mem[held_reg[IW-1:0]] <= head_data.key;
            tag_mem[held_reg[IW-1:0]] <= TSW'(head_data.tag);
        end
        if (sc_issue)
        begin
            rk_reg <= key_mem[sc_idx_reg[IW-1:0]];
            rt_reg <= tag_mem[sc_idx_reg[IW-1:0]];
        end
    end

    // Sorted stores: written at the scattered position, read in order on emission.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCATTER && sc_pend_reg)
        begin
            skey_mem[pos[IW-1:0]] <= rk_reg;
            stag_mem[pos[IW-1:0]] <= rt_reg;
        end
        if (state_reg == ST_EMIT_RD && out_free)
        begin
            ek_reg <= skey_mem[em_idx_reg[IW-1:0]];
            et_reg <= stag_mem[em_idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            held_reg    <= '0;
            drop_reg    <= 1'b0;
            pf_idx_reg  <= '0;
            acc_reg     <= '0;
            sc_idx_reg  <= '0;
            sc_pend_reg <= 1'b0;
            em_idx_reg  <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (ov_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (head_valid)
                    begin
                        if (keep)
                        begin
                            cnt_reg[KW'(head_data.key)] <= cnt_reg[KW'(head_data.key)] + 1'b1;
                            held_reg <= held_reg + 1'b1;
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                    pf_idx_reg <= '0;
                    acc_reg    <= '0;
                end
                ST_PREFIX:
                begin
                    // Tallies become start positions in place.
                    cnt_reg[pf_idx_reg] <= acc_reg;
                    acc_reg    <= acc_reg + cnt_reg[pf_idx_reg];
                    pf_idx_reg <= pf_idx_reg + 1'b1;
                    sc_idx_reg <= '0;
                end
                ST_SCATTER:
                begin
                    sc_pend_reg <= sc_issue;
                    if (sc_issue)
                    begin
                        sc_idx_reg <= sc_idx_reg + 1'b1;
                    end
                    if (sc_pend_reg)
                    begin
                        cnt_reg[rk_idx] <= pos + 1'b1;
                    end
                    em_idx_reg <= '0;
                end
                ST_EMIT_RD:
                begin
                end
                ST_EMIT_WR:
                begin
                    ok_reg     <= ek_reg;
                    ot_reg     <= 8'(et_reg);
                    ofin_reg   <= em_last;
                    odrop_reg  <= drop_reg;
                    oemp_reg   <= 1'b0;
                    em_idx_reg <= em_idx_reg + 1'b1;
                end
                ST_EMPTY:
                begin
                    if (out_free)
                    begin
                        ok_reg    <= '0;
                        ot_reg    <= '0;
                        ofin_reg  <= 1'b1;
                        odrop_reg <= drop_reg;
                        oemp_reg  <= 1'b1;
                    end
                end
                ST_CLEAR:
                begin
                    for (int i = 0; i < NUM_KEYS; i++)
                    begin
                        cnt_reg[i] <= '0;
                    end
                    held_reg <= '0;
                    drop_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid  = ov_reg;
    assign sorted_key = ok_reg;
    assign sorted_tag = ot_reg;
    assign final_res  = ofin_reg;
    assign dropped    = odrop_reg;
    assign empty_res  = oemp_reg;

endmodule

// ===== rtl/stable_counting_sort_tagged.sv =====
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   key, tag, batch_end
// output    out        out_valid / out_stall sorted_key, sorted_tag, final_res, dropped, empty_res
// config    in         cfg_wr_en             cfg_wr_data (max_key)
//
// Input beats are taken one per cycle into a four-entry queue until it fills; the back end
// drains it one beat per cycle while loading. On the closing beat the back end turns the
// tallies into start positions, scatters the held items, and emits each result through a
// read state and a write state, then clears the tallies; an empty batch gives one empty result.
// Reset clears the tallies, the item count and the drop flag at once; the item stores
// need no clearing. A stalled output holds its result and the back end waits on it,
// while the queue keeps accepting input until it fills.
module stable_counting_sort_tagged #(
    parameter int unsigned MAX_ITEMS = 64,
    parameter int unsigned NUM_KEYS  = 16,
    parameter int unsigned TAG_BITS  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] key,
    input  logic [7:0] tag,
    input  logic       batch_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] sorted_key,
    output logic [7:0] sorted_tag,
    output logic       final_res,
    output logic       dropped,
    output logic       empty_res
);
    import scst_pkg::*;

    scst_entry_t entry;
    scst_entry_t head_data;
    logic        full;
    logic        head_valid;
    logic        pop;

    // The front end holds max_key and marks each beat whose key is out of range.
    scst_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .key         (key),
        .tag         (tag),
        .batch_end   (batch_end),
        .entry       (entry)
    );

    // The queue lets the input side run ahead while the back end sorts or emits.
    scst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_data  (entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign in_stall = full;

    // The back end tallies, places and emits each batch.
    scst_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .NUM_KEYS  (NUM_KEYS),
        .TAG_BITS  (TAG_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_key (sorted_key),
        .sorted_tag (sorted_tag),
        .final_res  (final_res),
        .dropped    (dropped),
        .empty_res  (empty_res)
    );

endmodule
